/* rtl/kmsel_pkg.sv */
// Shared types and constants for the k-nearest midpoint select block.
`timescale 1ns / 1ps
package kmsel_pkg;

  localparam int INDEX_W  = 12;
  localparam int COORD_W  = 16;
  localparam int DIST_W   = 37;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 5;

  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]  dist_t;

  typedef enum logic [2:0] {
    REG_QUERY_START_X = 3'd0,
    REG_QUERY_START_Y = 3'd1,
    REG_QUERY_END_X   = 3'd2,
    REG_QUERY_END_Y   = 3'd3,
    REG_QUERY_INDEX   = 3'd4
  } reg_addr_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_WAIT,
    ST_DRAIN
  } state_t;

  // One slot of the sorted list.
  typedef struct packed {
    logic   valid;
    index_t index;
    dist_t  dsq;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{valid: 1'b0, index: '0, dsq: '1};

  // Word leaving the distance pipeline.
  typedef struct packed {
    logic   valid;
    logic   skip;
    logic   last;
    index_t index;
    dist_t  dsq;
  } dist_word_t;

  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

endpackage

/* rtl/k_nearest_midpoint_select_core.sv */
// Top level: config registers, distance pipeline, list cells, result drain.
// Segments are taken one per cycle while the list fills; each is inserted as it
// leaves the distance pipeline. After the last-marked segment is accepted, input stalls;
// the first result shows once that segment has been inserted, and NEIGHBOR_COUNT results
// in all follow, one per cycle as they are taken.
// Synchronous reset clears the query registers to zero and empties the list.
`timescale 1ns / 1ps
module k_nearest_midpoint_select_core #(
  parameter int NEIGHBOR_COUNT = 8,
  parameter int COORD_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kmsel_pkg::APB_AW-1:0]      paddr,
  input  logic [kmsel_pkg::APB_DW-1:0]      pwdata,
  output logic [kmsel_pkg::APB_DW-1:0]      prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [kmsel_pkg::INDEX_W-1:0]     line_index,
  input  logic [kmsel_pkg::COORD_W-1:0]     line_start_x,
  input  logic [kmsel_pkg::COORD_W-1:0]     line_start_y,
  input  logic [kmsel_pkg::COORD_W-1:0]     line_end_x,
  input  logic [kmsel_pkg::COORD_W-1:0]     line_end_y,
  input  logic                              last_line,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kmsel_pkg::INDEX_W-1:0]     neighbor_index,
  output logic                              neighbor_valid,
  output logic [kmsel_pkg::DIST_W-1:0]      neighbor_distance_sq,
  output logic                              last_of_run
);

  localparam int CNT_W = (NEIGHBOR_COUNT > 1) ? $clog2(NEIGHBOR_COUNT) : 1;

  kmsel_pkg::coord_t     query_start_x, query_start_y, query_end_x, query_end_y;
  kmsel_pkg::index_t     query_index;
  kmsel_pkg::state_t     state, state_next;
  kmsel_pkg::dist_word_t word;
  kmsel_pkg::cell_ctrl_t ctrl;
  kmsel_pkg::entry_t     new_entry;
  kmsel_pkg::entry_t     cell_entry [NEIGHBOR_COUNT];
  logic                  cell_take  [NEIGHBOR_COUNT];
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic                  cfg_write, in_fire, out_fire;

  // ---------------- config port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_start_x <= '0;
      query_start_y <= '0;
      query_end_x   <= '0;
      query_end_y   <= '0;
      query_index   <= '0;
    end else if (cfg_write) begin
      unique case (kmsel_pkg::reg_addr_t'(paddr[4:2]))
        kmsel_pkg::REG_QUERY_START_X: query_start_x <= pwdata[kmsel_pkg::COORD_W-1:0];
        kmsel_pkg::REG_QUERY_START_Y: query_start_y <= pwdata[kmsel_pkg::COORD_W-1:0];
        kmsel_pkg::REG_QUERY_END_X:   query_end_x   <= pwdata[kmsel_pkg::COORD_W-1:0];
        kmsel_pkg::REG_QUERY_END_Y:   query_end_y   <= pwdata[kmsel_pkg::COORD_W-1:0];
        kmsel_pkg::REG_QUERY_INDEX:   query_index   <= pwdata[kmsel_pkg::INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (kmsel_pkg::reg_addr_t'(paddr[4:2]))
      kmsel_pkg::REG_QUERY_START_X: prdata = kmsel_pkg::APB_DW'(query_start_x);
      kmsel_pkg::REG_QUERY_START_Y: prdata = kmsel_pkg::APB_DW'(query_start_y);
      kmsel_pkg::REG_QUERY_END_X:   prdata = kmsel_pkg::APB_DW'(query_end_x);
      kmsel_pkg::REG_QUERY_END_Y:   prdata = kmsel_pkg::APB_DW'(query_end_y);
      kmsel_pkg::REG_QUERY_INDEX:   prdata = kmsel_pkg::APB_DW'(query_index);
      default:                      prdata = '0;
    endcase
  end

  // ---------------- distance pipeline ----------------
  assign in_fire = in_valid && in_ready;

  kmsel_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_fire),
    .line_index   (line_index),
    .line_start_x (line_start_x),
    .line_start_y (line_start_y),
    .line_end_x   (line_end_x),
    .line_end_y   (line_end_y),
    .last_line    (last_line),
    .query_start_x(query_start_x),
    .query_start_y(query_start_y),
    .query_end_x  (query_end_x),
    .query_end_y  (query_end_y),
    .query_index  (query_index),
    .word         (word)
  );

  // ---------------- list cells ----------------
  assign out_fire    = out_valid && out_ready;
  assign ctrl.insert = word.valid && !word.skip;
  assign ctrl.drain  = out_fire;
  assign new_entry   = '{valid: 1'b1, index: word.index, dsq: word.dsq};

  for (genvar j = 0; j < NEIGHBOR_COUNT; j++) begin : g_cell
    logic              prev_take;
    kmsel_pkg::entry_t left_entry, right_entry;

    if (j == 0) begin : g_head
      assign prev_take  = 1'b0;
      assign left_entry = kmsel_pkg::ENTRY_EMPTY;
    end else begin : g_mid
      assign prev_take  = cell_take[j-1];
      assign left_entry = cell_entry[j-1];
    end

    // tail refills with an empty slot while draining
    if (j == NEIGHBOR_COUNT - 1) begin : g_tail
      assign right_entry = kmsel_pkg::ENTRY_EMPTY;
    end else begin : g_body
      assign right_entry = cell_entry[j+1];
    end

    kmsel_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_entry  (new_entry),
      .prev_take  (prev_take),
      .left_entry (left_entry),
      .right_entry(right_entry),
      .take       (cell_take[j]),
      .entry      (cell_entry[j])
    );
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmsel_pkg::ST_FILL;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    last_of_run = 1'b0;
    unique case (state)
      kmsel_pkg::ST_FILL: begin
        in_ready = 1'b1;
        if (in_valid && last_line) begin
          state_next = kmsel_pkg::ST_WAIT;
        end
      end
      kmsel_pkg::ST_WAIT: begin
        if (word.valid && word.last) begin
          state_next = kmsel_pkg::ST_DRAIN;
          cnt_next   = '0;
        end
      end
      kmsel_pkg::ST_DRAIN: begin
        out_valid   = 1'b1;
        last_of_run = (cnt == CNT_W'(NEIGHBOR_COUNT - 1));
        if (out_ready) begin
          cnt_next = cnt + 1'b1;
          if (last_of_run) begin
            state_next = kmsel_pkg::ST_FILL;
          end
        end
      end
      default: state_next = kmsel_pkg::ST_FILL;
    endcase
  end

  assign neighbor_index       = cell_entry[0].index;
  assign neighbor_valid       = cell_entry[0].valid;
  assign neighbor_distance_sq = cell_entry[0].dsq;

  // ---------------- checks ----------------
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready && !word.valid)
    else $error("input taken or pipeline busy while results drain");

  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(word.valid && word.last))
    else $error("drain began without a last word leaving the pipeline");

  a_list_cleared: assert property (@(posedge clk) disable iff (rst)
    out_fire && last_of_run |=> !cell_entry[0].valid && !out_valid)
    else $error("list not empty after final result");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (NEIGHBOR_COUNT > 1) && cell_entry[0].valid && cell_entry[NEIGHBOR_COUNT-1].valid
      |-> cell_entry[0].dsq <= cell_entry[NEIGHBOR_COUNT-1].dsq)
    else $error("list order broken");

endmodule

/* rtl/kmsel_dist.sv */
// Three-stage squared midpoint distance pipeline.
`timescale 1ns / 1ps
module kmsel_dist #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  kmsel_pkg::index_t       line_index,
  input  kmsel_pkg::coord_t       line_start_x,
  input  kmsel_pkg::coord_t       line_start_y,
  input  kmsel_pkg::coord_t       line_end_x,
  input  kmsel_pkg::coord_t       line_end_y,
  input  logic                    last_line,
  input  kmsel_pkg::coord_t       query_start_x,
  input  kmsel_pkg::coord_t       query_start_y,
  input  kmsel_pkg::coord_t       query_end_x,
  input  kmsel_pkg::coord_t       query_end_y,
  input  kmsel_pkg::index_t       query_index,
  output kmsel_pkg::dist_word_t   word
);

  localparam int CW  = (COORD_BITS < kmsel_pkg::COORD_W) ? COORD_BITS : kmsel_pkg::COORD_W;
  localparam int SW  = CW + 1;
  localparam int SQW = 2 * SW;

  logic [SW-1:0]  qx, qy, lx, ly, dx_c, dy_c;
  logic [SW-1:0]  dx1, dy1;
  logic [SQW-1:0] sqx2, sqy2;
  logic [SQW:0]   dsum;
  logic           v1, v2, v3;
  logic           skip1, skip2, skip3;
  logic           last1, last2, last3;
  kmsel_pkg::index_t idx1, idx2, idx3;
  kmsel_pkg::dist_t  dist3;

  // endpoint sums stand in for midpoints, so no halving
  always_comb begin
    qx = {1'b0, query_start_x[CW-1:0]} + {1'b0, query_end_x[CW-1:0]};
    qy = {1'b0, query_start_y[CW-1:0]} + {1'b0, query_end_y[CW-1:0]};
    lx = {1'b0, line_start_x[CW-1:0]} + {1'b0, line_end_x[CW-1:0]};
    ly = {1'b0, line_start_y[CW-1:0]} + {1'b0, line_end_y[CW-1:0]};
    dx_c = (qx >= lx) ? (qx - lx) : (lx - qx);
    dy_c = (qy >= ly) ? (qy - ly) : (ly - qy);
    dsum = {1'b0, sqx2} + {1'b0, sqy2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dx1   <= dx_c;
    dy1   <= dy_c;
    idx1  <= line_index;
    skip1 <= (line_index == query_index);
    last1 <= last_line;
    sqx2  <= dx1 * dx1;
    sqy2  <= dy1 * dy1;
    idx2  <= idx1;
    skip2 <= skip1;
    last2 <= last1;
    dist3 <= kmsel_pkg::dist_t'(dsum);
    idx3  <= idx2;
    skip3 <= skip2;
    last3 <= last2;
  end

  assign word = '{valid: v3, skip: skip3, last: last3, index: idx3, dsq: dist3};

endmodule

/* rtl/kmsel_cell.sv */
// One slot of the sorted list: compare, insert and shift.
`timescale 1ns / 1ps
module kmsel_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  kmsel_pkg::cell_ctrl_t ctrl,
  input  kmsel_pkg::entry_t     new_entry,
  input  logic                  prev_take,
  input  kmsel_pkg::entry_t     left_entry,
  input  kmsel_pkg::entry_t     right_entry,
  output logic                  take,
  output kmsel_pkg::entry_t     entry
);

  kmsel_pkg::entry_t entry_next;

  // ties go in front of the kept entry
  assign take = !entry.valid || (new_entry.dsq <= entry.dsq);

  always_comb begin
    entry_next = entry;
    priority if (ctrl.drain) begin
      entry_next = right_entry;
    end else if (ctrl.insert && prev_take) begin
      entry_next = left_entry;
    end else if (ctrl.insert && take) begin
      entry_next = new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= kmsel_pkg::ENTRY_EMPTY;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the k-nearest midpoint select core.
`timescale 1ns / 1ps
module tb_top;

  localparam int NEIGHBORS = 8;
  localparam int PHASE_SEGS = 68;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    kmsel_pkg::index_t idx;
    kmsel_pkg::coord_t sx;
    kmsel_pkg::coord_t sy;
    kmsel_pkg::coord_t ex;
    kmsel_pkg::coord_t ey;
    logic              last;
  } seg_t;

  typedef struct packed {
    kmsel_pkg::index_t idx;
    logic              ok;
    kmsel_pkg::dist_t  dsq;
    logic              tail;
  } neighbor_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [kmsel_pkg::APB_AW-1:0]   paddr = '0;
  logic [kmsel_pkg::APB_DW-1:0]   pwdata = '0;
  logic [kmsel_pkg::APB_DW-1:0]   prdata;
  logic                           pready;

  logic              in_valid = 1'b0;
  logic              in_ready;
  kmsel_pkg::index_t line_index = '0;
  kmsel_pkg::coord_t line_start_x = '0;
  kmsel_pkg::coord_t line_start_y = '0;
  kmsel_pkg::coord_t line_end_x = '0;
  kmsel_pkg::coord_t line_end_y = '0;
  logic              last_line = 1'b0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  kmsel_pkg::index_t neighbor_index;
  logic              neighbor_valid;
  kmsel_pkg::dist_t  neighbor_distance_sq;
  logic              last_of_run;

  k_nearest_midpoint_select_core #(
    .NEIGHBOR_COUNT(NEIGHBORS),
    .COORD_BITS(kmsel_pkg::COORD_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .line_index(line_index),
    .line_start_x(line_start_x),
    .line_start_y(line_start_y),
    .line_end_x(line_end_x),
    .line_end_y(line_end_y),
    .last_line(last_line),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .neighbor_index(neighbor_index),
    .neighbor_valid(neighbor_valid),
    .neighbor_distance_sq(neighbor_distance_sq),
    .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  // query copy held by the testbench
  kmsel_pkg::coord_t q_sx = '0;
  kmsel_pkg::coord_t q_sy = '0;
  kmsel_pkg::coord_t q_ex = '0;
  kmsel_pkg::coord_t q_ey = '0;
  kmsel_pkg::index_t q_index = '0;

  // sorted nearest list mirror
  kmsel_pkg::dist_t  kept_dsq [NEIGHBORS];
  kmsel_pkg::index_t kept_idx [NEIGHBORS];
  logic              kept_ok  [NEIGHBORS];

  seg_t      pending_segs[$];
  neighbor_t nearest_due[$];
  seg_t      cur_seg;
  seg_t      prev_seg = '0;

  int errors = 0;
  int segs_queued = 0;
  int segs_accepted = 0;
  int runs_done = 0;
  int words_checked = 0;
  int reg_writes = 0;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  bit   src_idle_on = 1'b0;
  bit   snk_idle_on = 1'b0;
  int   src_gap = 0;
  int   snk_gap = 0;
  int   snk_draw;
  int   hold_len = 0;
  int   hold_id = 0;
  int   hold_ack = 0;
  int   hold_left = 0;

  function automatic int draw_gap(bit busy);
    int r;
    if (!busy) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_kept();
    for (int k = 0; k < NEIGHBORS; k++) begin
      kept_dsq[k] = '1;
      kept_idx[k] = '0;
      kept_ok[k]  = 1'b0;
    end
  endfunction

  // Insert one accepted segment unless it carries the query index; on the last mark queue the whole list.
  function automatic void rank_segment(seg_t s);
    logic [kmsel_pkg::COORD_W:0] qx, qy, lx, ly, dx, dy;
    kmsel_pkg::dist_t d;
    bit placed;
    neighbor_t w;
    placed = 1'b0;
    if (s.idx != q_index) begin
      qx = {1'b0, q_sx} + {1'b0, q_ex};
      qy = {1'b0, q_sy} + {1'b0, q_ey};
      lx = {1'b0, s.sx} + {1'b0, s.ex};
      ly = {1'b0, s.sy} + {1'b0, s.ey};
      dx = (qx >= lx) ? qx - lx : lx - qx;
      dy = (qy >= ly) ? qy - ly : ly - qy;
      d = kmsel_pkg::dist_t'(dx) * kmsel_pkg::dist_t'(dx)
        + kmsel_pkg::dist_t'(dy) * kmsel_pkg::dist_t'(dy);
      // ties land in front of the kept entry
      for (int j = 0; j < NEIGHBORS && !placed; j++) begin
        if (!kept_ok[j] || d <= kept_dsq[j]) begin
          for (int k = NEIGHBORS - 1; k > j; k--) begin
            kept_dsq[k] = kept_dsq[k-1];
            kept_idx[k] = kept_idx[k-1];
            kept_ok[k]  = kept_ok[k-1];
          end
          kept_dsq[j] = d;
          kept_idx[j] = s.idx;
          kept_ok[j]  = 1'b1;
          placed = 1'b1;
        end
      end
    end
    if (s.last) begin
      for (int k = 0; k < NEIGHBORS; k++) begin
        w.idx  = kept_ok[k] ? kept_idx[k] : '0;
        w.ok   = kept_ok[k];
        w.dsq  = kept_ok[k] ? kept_dsq[k] : '1;
        w.tail = (k == NEIGHBORS - 1);
        nearest_due = {nearest_due, w};
      end
      clear_kept();
      runs_done++;
    end
  endfunction

  function automatic void check_field(string what, logic [kmsel_pkg::DIST_W-1:0] want,
                                      logic [kmsel_pkg::DIST_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, what, want, got);
    end
  endfunction

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    neighbor_t w;
    in_taken  <= in_valid && in_ready;
    out_taken <= out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      if (nearest_due.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result word, expected none, actual index 0x%0h dist 0x%0h",
                 $time, neighbor_index, neighbor_distance_sq);
      end else begin
        w = nearest_due.pop_front();
        check_field("neighbor_index", kmsel_pkg::DIST_W'(w.idx),
                    kmsel_pkg::DIST_W'(neighbor_index));
        check_field("neighbor_valid", kmsel_pkg::DIST_W'(w.ok),
                    kmsel_pkg::DIST_W'(neighbor_valid));
        check_field("neighbor_distance_sq", w.dsq, neighbor_distance_sq);
        check_field("last_of_run", kmsel_pkg::DIST_W'(w.tail),
                    kmsel_pkg::DIST_W'(last_of_run));
        words_checked++;
      end
    end
    if (!rst && in_valid && in_ready) begin
      rank_segment({line_index, line_start_x, line_start_y, line_end_x, line_end_y,
                    last_line});
      segs_accepted++;
    end
  end

  // Segment driver.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the word until it is taken
    end else if (src_gap > 0) begin
      src_gap <= src_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_segs.size() != 0) begin
      cur_seg = pending_segs.pop_front();
      line_index   <= cur_seg.idx;
      line_start_x <= cur_seg.sx;
      line_start_y <= cur_seg.sy;
      line_end_x   <= cur_seg.ex;
      line_end_y   <= cur_seg.ey;
      last_line    <= cur_seg.last;
      in_valid     <= 1'b1;
      src_gap      <= draw_gap(src_idle_on);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result sink with random back-pressure and an optional long hold.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_id != hold_ack) begin
      hold_ack  <= hold_id;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      out_ready <= 1'b0;
    end else begin
      snk_draw = draw_gap(snk_idle_on);
      if (out_taken && snk_draw > 0) begin
        out_ready <= 1'b0;
        snk_gap   <= snk_draw - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic apb_cycle(input bit wr, input kmsel_pkg::reg_addr_t r,
                           input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_query_reg(kmsel_pkg::reg_addr_t r, logic [31:0] v);
    logic [31:0] mask, rd;
    mask = (r == kmsel_pkg::REG_QUERY_INDEX) ? 32'h0000_0FFF : 32'h0000_FFFF;
    apb_cycle(1'b1, r, v, rd);
    apb_cycle(1'b0, r, '0, rd);
    check_field("register readback", kmsel_pkg::DIST_W'(v & mask), kmsel_pkg::DIST_W'(rd));
    reg_writes++;
    case (r)
      kmsel_pkg::REG_QUERY_START_X: q_sx = kmsel_pkg::coord_t'(v);
      kmsel_pkg::REG_QUERY_START_Y: q_sy = kmsel_pkg::coord_t'(v);
      kmsel_pkg::REG_QUERY_END_X:   q_ex = kmsel_pkg::coord_t'(v);
      kmsel_pkg::REG_QUERY_END_Y:   q_ey = kmsel_pkg::coord_t'(v);
      kmsel_pkg::REG_QUERY_INDEX:   q_index = kmsel_pkg::index_t'(v);
      default: ;
    endcase
  endtask

  task automatic load_query(kmsel_pkg::coord_t sx, kmsel_pkg::coord_t sy,
                            kmsel_pkg::coord_t ex, kmsel_pkg::coord_t ey,
                            kmsel_pkg::index_t qi);
    write_query_reg(kmsel_pkg::REG_QUERY_START_X, 32'(sx));
    write_query_reg(kmsel_pkg::REG_QUERY_START_Y, 32'(sy));
    write_query_reg(kmsel_pkg::REG_QUERY_END_X, 32'(ex));
    write_query_reg(kmsel_pkg::REG_QUERY_END_Y, 32'(ey));
    write_query_reg(kmsel_pkg::REG_QUERY_INDEX, 32'(qi));
  endtask

  task automatic push_seg(kmsel_pkg::index_t i, kmsel_pkg::coord_t sx, kmsel_pkg::coord_t sy,
                          kmsel_pkg::coord_t ex, kmsel_pkg::coord_t ey, bit last);
    seg_t s;
    s = {i, sx, sy, ex, ey, last};
    pending_segs = {pending_segs, s};
    prev_seg = s;
    segs_queued++;
  endtask

  function automatic kmsel_pkg::coord_t near_coord(kmsel_pkg::coord_t c);
    return kmsel_pkg::coord_t'(c + kmsel_pkg::coord_t'($urandom_range(0, 64))
                               - kmsel_pkg::coord_t'(32));
  endfunction

  function automatic kmsel_pkg::coord_t edge_coord();
    return $urandom_range(0, 1) ? '1 : '0;
  endfunction

  // One list run of random segments, the final one marked last.
  task automatic queue_run(int len);
    kmsel_pkg::index_t i;
    kmsel_pkg::coord_t sx, sy, ex, ey;
    int r, m;
    for (int n = 0; n < len; n++) begin
      r = $urandom_range(0, 99);
      if (r < 12) i = q_index;
      else if (r < 22) i = kmsel_pkg::index_t'($urandom_range(0, 15));
      else if (r < 27) i = '1;
      else i = kmsel_pkg::index_t'($urandom_range(0, 4095));
      m = $urandom_range(0, 99);
      if (m < 40) begin
        sx = kmsel_pkg::coord_t'($urandom); sy = kmsel_pkg::coord_t'($urandom);
        ex = kmsel_pkg::coord_t'($urandom); ey = kmsel_pkg::coord_t'($urandom);
      end else if (m < 65) begin
        sx = near_coord(q_sx); sy = near_coord(q_sy);
        ex = near_coord(q_ex); ey = near_coord(q_ey);
      end else if (m < 75) begin
        // same midpoint as the previous segment: exercises ties
        sx = prev_seg.ex; sy = prev_seg.ey; ex = prev_seg.sx; ey = prev_seg.sy;
      end else if (m < 85) begin
        sx = edge_coord(); sy = edge_coord(); ex = edge_coord(); ey = edge_coord();
      end else begin
        sx = q_ex; sy = q_ey; ex = q_sx; ey = q_sy;
      end
      push_seg(i, sx, sy, ex, ey, n == len - 1);
    end
  endtask

  function automatic int draw_run_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 1;
    if (r < 20) return $urandom_range(2, 7);
    if (r < 85) return $urandom_range(8, 20);
    return $urandom_range(21, 40);
  endfunction

  function automatic kmsel_pkg::coord_t draw_query_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return kmsel_pkg::coord_t'($urandom);
  endfunction

  // Wait until every queued segment is taken and every result has come back.
  task automatic wait_idle();
    while (segs_accepted != segs_queued || nearest_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int phase_segs, len;
    clear_kept();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: query at the origin, index 0
    load_query('0, '0, '0, '0, '0);
    push_seg('0, '0, '0, '0, '0, 1'b1);
    push_seg(12'd5, '0, '0, '0, '0, 1'b1);
    push_seg('1, '1, '1, '1, '1, 1'b0);
    push_seg(12'd1, 16'd16, 16'd16, 16'd16, 16'd16, 1'b0);
    push_seg(12'd2, 16'd16, 16'd16, 16'd16, 16'd16, 1'b0);
    push_seg('0, 16'd5, 16'd5, 16'd5, 16'd5, 1'b0);
    push_seg(12'd3, '0, '0, '0, '0, 1'b0);
    push_seg(12'd4, '1, '0, '0, '1, 1'b0);
    push_seg(12'd6, '0, '1, '1, '0, 1'b0);
    push_seg(12'd7, 16'd1, 16'd2, 16'd3, 16'd4, 1'b0);
    push_seg(12'd8, 16'd16, 16'd16, 16'd16, 16'd16, 1'b0);
    push_seg(12'd9, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
    push_seg(12'd10, '0, '0, 16'd1, '0, 1'b0);
    push_seg('0, '1, '1, '0, '0, 1'b1);
    wait_idle();

    // directed: query at the far corner, top index
    load_query('1, '1, '1, '1, '1);
    push_seg('1, '0, '0, '0, '0, 1'b0);
    push_seg('0, '0, '0, '0, '0, 1'b0);
    push_seg(12'd100, '1, '1, '1, '1, 1'b0);
    push_seg(12'd200, '0, '1, '1, '0, 1'b1);
    push_seg('1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_query(draw_query_coord(), draw_query_coord(), draw_query_coord(),
                      draw_query_coord(), kmsel_pkg::index_t'($urandom_range(0, 4095)));
        3: load_query('1, '1, '0, '0, '1);
        5: load_query(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, '0);
        default: load_query(draw_query_coord(), draw_query_coord(), draw_query_coord(),
                            draw_query_coord(), kmsel_pkg::index_t'($urandom_range(0, 31)));
      endcase
      src_idle_on = (ph != 0) && (ph != 2);
      snk_idle_on = (ph != 0);
      if (ph == 2) begin
        // long sink stall while the source streams back to back
        hold_len = 300;
        hold_id++;
      end
      phase_segs = 0;
      while (phase_segs < PHASE_SEGS) begin
        len = draw_run_len();
        queue_run(len);
        phase_segs += len;
      end
      wait_idle();
    end

    $display("Run covered %0d segments in %0d list runs, %0d result words checked,",
             segs_accepted, runs_done, words_checked);
    $display("  %0d register writes over 8 query settings, with stalls on both sides.",
             reg_writes);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout: %0d results still outstanding", nearest_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
rtl/kmsel_pkg.sv
rtl/kmsel_dist.sv
rtl/kmsel_cell.sv
rtl/k_nearest_midpoint_select_core.sv
verif/tb_top.sv
